// ----- design/irtpd_pkg.sv -----
package irtpd_pkg;

   localparam int unsigned DATA_BITS        = 8;
   localparam int unsigned LENGTH_BITS      = 14;
   localparam int unsigned DURATION_BITS    = 24;
   localparam int unsigned TICK_BITS        = 32;
   localparam int unsigned PERIOD_BITS      = 10;
   localparam int unsigned MAX_PACKET_BYTES = 8192;

   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET  = PERIOD_BITS'(61);
   localparam logic [DATA_BITS-1:0]   SPACE_BIT_MASK = DATA_BITS'(8'h80);
   localparam logic [14:0]            WORD_TICK_MASK = 15'h7FFF;
   localparam logic [LENGTH_BITS-1:0] EXT_BYTES      = LENGTH_BITS'(4);

   typedef struct packed {
      logic [DATA_BITS-1:0]   data_byte;
      logic                   first_of_packet;
      logic [LENGTH_BITS-1:0] packet_length;
   } req_payload_type;

   typedef struct packed {
      logic                     is_pulse;
      logic [DURATION_BITS-1:0] duration;
   } rsp_payload_type;

endpackage

// ----- design/ir_timing_packet_decoder.sv -----
// ir timing packet decoder
// req_ channel: one packet byte per transfer, tagged with first_of_packet and the
//   packet's length, clamped and rounded down to even inside. csr_ channel:
//   tick_period_us, always ready, to be written only while the block is idle.
// rsp_ channel: one pulse/space interval for each completed 16-bit word or 4-byte
//   extended duration, duration = ticks * tick_period_us saturated to 24 bits.
// one byte is taken per cycle while req_stall is low. the byte that completes an
//   interval is decoded in the accept cycle, its tick count is registered in the
//   mid stage, then the multiply and saturate stage loads the rsp register.
// the decode state advances at the input register; the multiply stage and the
//   result register each hold one item, so bytes keep flowing while a result
//   waits. when rsp_stall stays high and both stages are full, req_stall rises.
// reset (synchronous, active high) clears the decode state, empties both stages
//   and sets tick_period_us to 61.
module ir_timing_packet_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  irtpd_pkg::req_payload_type          req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output irtpd_pkg::rsp_payload_type          rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [irtpd_pkg::PERIOD_BITS-1:0]   csr_data
);

   localparam int unsigned LW     = irtpd_pkg::LENGTH_BITS;
   localparam int unsigned DW     = irtpd_pkg::DATA_BITS;
   localparam int unsigned TW     = irtpd_pkg::TICK_BITS;
   localparam int unsigned OW     = irtpd_pkg::DURATION_BITS;
   localparam int unsigned PROD_W = irtpd_pkg::TICK_BITS + irtpd_pkg::PERIOD_BITS;

   typedef enum logic [2:0] {
      PHASE_LOW,
      PHASE_HIGH,
      PHASE_EXT0,
      PHASE_EXT1,
      PHASE_EXT2,
      PHASE_EXT3
   } phase_type;

   phase_type                         phase_ff, phase_in;
   logic [LW-1:0]                     pos_ff, pos_in;
   logic [DW-1:0]                     low_ff, low_in;
   logic [TW-1:0]                     acc_ff, acc_in;
   logic                              pend_ff, pend_in;
   logic                              skip_ff, skip_in;
   logic [irtpd_pkg::PERIOD_BITS-1:0] period_ff;

   logic                              mid_valid_ff;
   logic                              mid_pulse_ff;
   logic [TW-1:0]                     mid_ticks_ff;
   logic                              out_valid_ff;
   irtpd_pkg::rsp_payload_type        out_ff, out_in;

   logic                              accept;
   logic                              out_load;
   logic                              mid_load;
   logic [LW-1:0]                     len;
   logic                              res_valid;
   logic                              res_pulse;
   logic [TW-1:0]                     res_ticks;
   logic [14:0]                       word_ticks;
   logic [PROD_W-1:0]                 product;

   assign out_load  = !out_valid_ff || !rsp_stall;
   assign mid_load  = !mid_valid_ff || out_load;
   assign req_stall = !mid_load;
   assign accept    = req_valid && mid_load;
   assign csr_ready = 1'b1;

   // clamp to the largest packet, then drop the odd trailing byte
   always_comb begin
      if (req_payload.packet_length > LW'(irtpd_pkg::MAX_PACKET_BYTES)) begin
         len = LW'(irtpd_pkg::MAX_PACKET_BYTES);
      end else begin
         len = req_payload.packet_length;
      end
      len[0] = 1'b0;
   end

   assign word_ticks = 15'({req_payload.data_byte, low_ff}) & irtpd_pkg::WORD_TICK_MASK;

   always_comb begin
      logic go;
      go        = 1'b1;
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      low_in    = low_ff;
      acc_in    = acc_ff;
      pend_in   = pend_ff;
      skip_in   = skip_ff;
      res_valid = 1'b0;
      res_pulse = 1'b0;
      res_ticks = '0;
      if (accept) begin
         if (req_payload.first_of_packet) begin
            if (skip_ff) begin
               skip_in = 1'b0;
               // follow-up packet too short to hold the deferred value
               if (len < irtpd_pkg::EXT_BYTES) begin
                  phase_in = PHASE_LOW;
                  pend_in  = 1'b0;
                  acc_in   = '0;
               end
            end else if (phase_ff != PHASE_LOW) begin
               phase_in = PHASE_LOW;
               pend_in  = 1'b0;
               acc_in   = '0;
            end
            pos_in = '0;
         end else if (skip_ff) begin
            go = 1'b0;
         end
         if (go && pos_in < len) begin
            pos_in = pos_in + LW'(1);
            case (phase_in)
               PHASE_LOW: begin
                  low_in   = req_payload.data_byte;
                  phase_in = PHASE_HIGH;
               end
               PHASE_HIGH: begin
                  if (word_ticks != '0) begin
                     phase_in  = PHASE_LOW;
                     res_valid = 1'b1;
                     res_pulse = (req_payload.data_byte & irtpd_pkg::SPACE_BIT_MASK) == '0;
                     res_ticks = TW'(word_ticks);
                  end else begin
                     pend_in  = (req_payload.data_byte & irtpd_pkg::SPACE_BIT_MASK) == '0;
                     acc_in   = '0;
                     phase_in = PHASE_EXT0;
                     // extended value does not fit: it comes from the next packet
                     if (len - pos_in < irtpd_pkg::EXT_BYTES) begin
                        skip_in = 1'b1;
                     end
                  end
               end
               PHASE_EXT0: begin
                  acc_in[7:0] = acc_in[7:0] | req_payload.data_byte;
                  phase_in    = PHASE_EXT1;
               end
               PHASE_EXT1: begin
                  acc_in[15:8] = acc_in[15:8] | req_payload.data_byte;
                  phase_in     = PHASE_EXT2;
               end
               PHASE_EXT2: begin
                  acc_in[23:16] = acc_in[23:16] | req_payload.data_byte;
                  phase_in      = PHASE_EXT3;
               end
               PHASE_EXT3: begin
                  acc_in[31:24] = acc_in[31:24] | req_payload.data_byte;
                  phase_in      = PHASE_LOW;
                  res_valid     = 1'b1;
                  res_pulse     = pend_in;
                  res_ticks     = acc_in;
                  pend_in       = 1'b0;
               end
               default: begin
                  phase_in = PHASE_LOW;
               end
            endcase
         end
      end
   end

   assign product = PROD_W'(mid_ticks_ff) * PROD_W'(period_ff);

   always_comb begin
      out_in.is_pulse = mid_pulse_ff;
      if (product[PROD_W-1:OW] != '0) begin
         out_in.duration = '1;
      end else begin
         out_in.duration = product[OW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_LOW;
         pos_ff       <= '0;
         low_ff       <= '0;
         acc_ff       <= '0;
         pend_ff      <= 1'b0;
         skip_ff      <= 1'b0;
         period_ff    <= irtpd_pkg::PERIOD_RESET;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         low_ff   <= low_in;
         acc_ff   <= acc_in;
         pend_ff  <= pend_in;
         skip_ff  <= skip_in;
         if (csr_valid && csr_ready) begin
            period_ff <= csr_data;
         end
         if (mid_load) begin
            mid_valid_ff <= res_valid;
         end
         if (out_load) begin
            out_valid_ff <= mid_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mid_load) begin
         mid_pulse_ff <= res_pulse;
         mid_ticks_ff <= res_ticks;
      end
      if (out_load && mid_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule
